// ----- rtl/wsp_pkg.sv -----
// Package for the WAV stream parser: phase codes, tags, result kinds and the result record.
`default_nettype none
package wsp_pkg;

  // Chunk tags as they appear in a big-endian window of the last four bytes
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Byte counts inside fixed-length fields
  localparam logic [4:0] TAG_BYTES      = 5'd4;
  localparam logic [4:0] SEEK_FILL_LAST = 5'd3;
  localparam logic [4:0] FMT_BODY_BYTES = 5'd20;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NO_RIFF  = 2'd0;
  localparam logic [1:0] ERR_NO_WAVE  = 2'd1;
  localparam logic [1:0] ERR_BAD_BITS = 2'd2;

  // Parse phases
  typedef enum logic [3:0] {
    PH_RIFF_TAG  = 4'd0,
    PH_RIFF_SIZE = 4'd1,
    PH_WAVE_TAG  = 4'd2,
    PH_FMT_SEEK  = 4'd3,
    PH_FMT_BODY  = 4'd4,
    PH_DATA_SEEK = 4'd5,
    PH_DATA_SIZE = 4'd6,
    PH_SAMPLES   = 4'd7,
    PH_IDLE      = 4'd8
  } phase_t;

  // One result item
  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] sample_value;
    logic               last_sample;
    logic [15:0]        format_code;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [31:0]        byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        sample_bits;
    logic [31:0]        data_bytes;
    logic [1:0]         error_code;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/wsp_byte_if.sv -----
// Valid/ready channel that carries one byte of the WAV stream per item.
`default_nettype none
interface wsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface
`default_nettype wire

// ----- rtl/wsp_result_if.sv -----
// Valid/ready channel that carries one parser result per item.
`default_nettype none
interface wsp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [31:0] sample_value;
  logic               last_sample;
  logic [15:0]        format_code;
  logic [15:0]        channel_count;
  logic [31:0]        sample_rate;
  logic [31:0]        byte_rate;
  logic [15:0]        block_align;
  logic [15:0]        sample_bits;
  logic [31:0]        data_bytes;
  logic [1:0]         error_code;

  modport source (
    output valid, output result_kind, output sample_value, output last_sample,
    output format_code, output channel_count, output sample_rate, output byte_rate,
    output block_align, output sample_bits, output data_bytes, output error_code,
    input ready
  );
  modport sink (
    input valid, input result_kind, input sample_value, input last_sample,
    input format_code, input channel_count, input sample_rate, input byte_rate,
    input block_align, input sample_bits, input data_bytes, input error_code,
    output ready
  );
endinterface
`default_nettype wire

// ----- rtl/wsp_core.sv -----
// Per-byte parse state machine: tag checks, format capture and sample assembly.
`default_nettype none
module wsp_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic [7:0]      data_byte,
  input  wire logic            file_start,
  output logic                 res_valid,
  output wsp_pkg::result_t     res
);

  wsp_pkg::phase_t phase, phase_next, cur_phase;
  logic [4:0]  idx, idx_next, cur_idx, idx_inc;
  logic [31:0] window, window_next;
  logic [15:0] fmt_code, fmt_code_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [31:0] brate, brate_next;
  logic [15:0] balign, balign_next;
  logic [15:0] sbits, sbits_next;
  logic [31:0] dbytes, dbytes_next, dbytes_shift;
  logic [31:0] acc, acc_next, acc_shift;
  logic [31:0] bytes_left, bytes_left_next;
  logic [2:0]  nb;
  logic        bits_ok;
  logic [31:0] sample_v;

  // A file start restarts the parser with this byte
  assign cur_phase    = file_start ? wsp_pkg::PH_RIFF_TAG : phase;
  assign cur_idx      = file_start ? 5'd0 : idx;
  assign idx_inc      = cur_idx + 5'd1;
  assign dbytes_shift = {data_byte, dbytes[31:8]};
  assign acc_shift    = {data_byte, acc[31:8]};

  // Bytes per sample and the legal sample sizes
  always_comb begin
    unique case (sbits)
      16'd8:   nb = 3'd1;
      16'd16:  nb = 3'd2;
      16'd24:  nb = 3'd3;
      default: nb = 3'd4;
    endcase
    bits_ok = (sbits == 16'd8) || (sbits == 16'd16) || (sbits == 16'd24) ||
              (sbits == 16'd32);
  end

  // Sample from the last nb bytes, little-endian
  always_comb begin
    unique case (nb)
      3'd1:    sample_v = {24'd0, acc_shift[31:24]};
      3'd2:    sample_v = {{16{acc_shift[31]}}, acc_shift[31:16]};
      3'd3:    sample_v = {{8{acc_shift[31]}}, acc_shift[31:8]};
      default: sample_v = acc_shift;
    endcase
  end

  // Next state and result
  always_comb begin
    phase_next      = cur_phase;
    idx_next        = cur_idx;
    window_next     = {window[23:0], data_byte};
    fmt_code_next   = fmt_code;
    chans_next      = chans;
    rate_next       = rate;
    brate_next      = brate;
    balign_next     = balign;
    sbits_next      = sbits;
    dbytes_next     = dbytes;
    acc_next        = acc;
    bytes_left_next = bytes_left;
    res_valid       = 1'b0;
    res             = '0;

    unique case (cur_phase)
      wsp_pkg::PH_RIFF_TAG, wsp_pkg::PH_WAVE_TAG: begin
        idx_next = idx_inc;
        if (idx_inc == wsp_pkg::TAG_BYTES) begin
          idx_next = 5'd0;
          if (cur_phase == wsp_pkg::PH_RIFF_TAG) begin
            if (window_next != wsp_pkg::TAG_RIFF) begin
              res_valid       = 1'b1;
              res.result_kind = wsp_pkg::KIND_ERROR;
              res.error_code  = wsp_pkg::ERR_NO_RIFF;
              phase_next      = wsp_pkg::PH_IDLE;
            end else begin
              phase_next = wsp_pkg::PH_RIFF_SIZE;
            end
          end else begin
            if (window_next != wsp_pkg::TAG_WAVE) begin
              res_valid       = 1'b1;
              res.result_kind = wsp_pkg::KIND_ERROR;
              res.error_code  = wsp_pkg::ERR_NO_WAVE;
              phase_next      = wsp_pkg::PH_IDLE;
            end else begin
              phase_next = wsp_pkg::PH_FMT_SEEK;
            end
          end
        end
      end
      wsp_pkg::PH_RIFF_SIZE: begin
        idx_next = idx_inc;
        if (idx_inc == wsp_pkg::TAG_BYTES) begin
          idx_next   = 5'd0;
          phase_next = wsp_pkg::PH_WAVE_TAG;
        end
      end
      wsp_pkg::PH_FMT_SEEK, wsp_pkg::PH_DATA_SEEK: begin
        // Window must first hold four bytes of this phase
        if (cur_idx < wsp_pkg::SEEK_FILL_LAST) begin
          idx_next = idx_inc;
        end else if (cur_phase == wsp_pkg::PH_FMT_SEEK && window_next == wsp_pkg::TAG_FMT) begin
          idx_next   = 5'd0;
          phase_next = wsp_pkg::PH_FMT_BODY;
        end else if (cur_phase == wsp_pkg::PH_DATA_SEEK &&
                     window_next == wsp_pkg::TAG_DATA) begin
          idx_next   = 5'd0;
          phase_next = wsp_pkg::PH_DATA_SIZE;
        end
      end
      wsp_pkg::PH_FMT_BODY: begin
        // Chunk size bytes first, then the six format fields
        if (cur_idx >= 5'd4 && cur_idx < 5'd6)        fmt_code_next = {data_byte, fmt_code[15:8]};
        else if (cur_idx >= 5'd6 && cur_idx < 5'd8)   chans_next    = {data_byte, chans[15:8]};
        else if (cur_idx >= 5'd8 && cur_idx < 5'd12)  rate_next     = {data_byte, rate[31:8]};
        else if (cur_idx >= 5'd12 && cur_idx < 5'd16) brate_next    = {data_byte, brate[31:8]};
        else if (cur_idx >= 5'd16 && cur_idx < 5'd18) balign_next   = {data_byte, balign[15:8]};
        else if (cur_idx >= 5'd18)                    sbits_next    = {data_byte, sbits[15:8]};
        idx_next = idx_inc;
        if (idx_inc == wsp_pkg::FMT_BODY_BYTES) begin
          idx_next   = 5'd0;
          phase_next = wsp_pkg::PH_DATA_SEEK;
        end
      end
      wsp_pkg::PH_DATA_SIZE: begin
        dbytes_next = dbytes_shift;
        idx_next    = idx_inc;
        if (idx_inc == wsp_pkg::TAG_BYTES) begin
          idx_next  = 5'd0;
          res_valid = 1'b1;
          if (!bits_ok) begin
            res.result_kind = wsp_pkg::KIND_ERROR;
            res.error_code  = wsp_pkg::ERR_BAD_BITS;
            phase_next      = wsp_pkg::PH_IDLE;
          end else begin
            res.result_kind   = wsp_pkg::KIND_HEADER;
            res.format_code   = fmt_code;
            res.channel_count = chans;
            res.sample_rate   = rate;
            res.byte_rate     = brate;
            res.block_align   = balign;
            res.sample_bits   = sbits;
            res.data_bytes    = dbytes_shift;
            // Remaining data bytes stand in for the sample count
            bytes_left_next   = dbytes_shift;
            acc_next          = '0;
            phase_next        = (dbytes_shift >= {29'd0, nb}) ? wsp_pkg::PH_SAMPLES
                                                              : wsp_pkg::PH_IDLE;
          end
        end
      end
      wsp_pkg::PH_SAMPLES: begin
        acc_next = acc_shift;
        idx_next = idx_inc;
        if (idx_inc == {2'd0, nb}) begin
          res_valid        = 1'b1;
          res.result_kind  = wsp_pkg::KIND_SAMPLE;
          res.sample_value = sample_v;
          idx_next         = 5'd0;
          acc_next         = '0;
          bytes_left_next  = bytes_left - {29'd0, nb};
          // Fewer than two samples' worth left means this one is the last
          if (bytes_left < {28'd0, nb, 1'b0}) begin
            res.last_sample = 1'b1;
            phase_next      = wsp_pkg::PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wsp_pkg::PH_RIFF_TAG;
      idx   <= 5'd0;
    end else if (fire) begin
      phase <= phase_next;
      idx   <= idx_next;
    end
  end

  // Captured fields and accumulators
  always_ff @(posedge clk) begin
    if (fire) begin
      window     <= window_next;
      fmt_code   <= fmt_code_next;
      chans      <= chans_next;
      rate       <= rate_next;
      brate      <= brate_next;
      balign     <= balign_next;
      sbits      <= sbits_next;
      dbytes     <= dbytes_next;
      acc        <= acc_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wsp_out_buf.sv -----
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module wsp_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire wsp_pkg::result_t in_res,
  output logic                  in_ready,
  output logic                  out_valid,
  output wsp_pkg::result_t      out_res,
  input  wire logic             out_ready
);

  logic             skid_valid;
  wsp_pkg::result_t skid_res;
  logic             out_free;

  assign in_ready = ~skid_valid;
  assign out_free = ~out_valid | out_ready;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid | in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : in_res;
    end else if (in_valid) begin
      skid_res <= in_res;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wav_stream_parser_top.sv -----
// Top level of the WAV stream parser: byte channel in, result channel out.
//
//  channel  | dir | payload                                        | item
//  ---------+-----+------------------------------------------------+-----------------
//  stream   | in  | data_byte, file_start                          | one file byte
//  result   | out | result_kind, sample_value, last_sample, header | header/sample/error
//           |     | fields, error_code                             |
//
// One byte is taken per clock while stream.ready is high; the result that a byte
// completes is registered in the output buffer. rst (synchronous) returns the parser to
// waiting for the RIFF tag. A two-entry output buffer lets bytes keep flowing
// while one result waits; stream.ready drops only when both entries are full.
`default_nettype none
module wav_stream_parser_top (
  input  wire logic     clk,
  input  wire logic     rst,
  wsp_byte_if.sink      stream,
  wsp_result_if.source  result
);

  logic             fire;
  logic             core_valid;
  wsp_pkg::result_t core_res;
  logic             buf_ready;
  wsp_pkg::result_t out_res;

  assign stream.ready = buf_ready;
  assign fire         = stream.valid & buf_ready;

  wsp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (stream.data_byte),
    .file_start (stream.file_start),
    .res_valid  (core_valid),
    .res        (core_res)
  );

  wsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fire & core_valid),
    .in_res    (core_res),
    .in_ready  (buf_ready),
    .out_valid (result.valid),
    .out_res   (out_res),
    .out_ready (result.ready)
  );

  assign result.result_kind   = out_res.result_kind;
  assign result.sample_value  = out_res.sample_value;
  assign result.last_sample   = out_res.last_sample;
  assign result.format_code   = out_res.format_code;
  assign result.channel_count = out_res.channel_count;
  assign result.sample_rate   = out_res.sample_rate;
  assign result.byte_rate     = out_res.byte_rate;
  assign result.block_align   = out_res.block_align;
  assign result.sample_bits   = out_res.sample_bits;
  assign result.data_bytes    = out_res.data_bytes;
  assign result.error_code    = out_res.error_code;

endmodule
`default_nettype wire
